@@ rtl/core/chc_pkg.sv @@
// Shared types, constants and helpers for the character histogram counter.
`default_nettype none

package chc_pkg;

  // Command codes carried in the input transaction
  localparam logic CmdCount = 1'b0;
  localparam logic CmdRead  = 1'b1;

  // Character codes used by the listed-set test
  localparam logic [6:0] ChUpperA = 7'h41;
  localparam logic [6:0] ChUpperZ = 7'h5A;
  localparam logic [6:0] ChLowerA = 7'h61;
  localparam logic [6:0] ChLowerZ = 7'h7A;
  localparam logic [6:0] ChDigit0 = 7'h30;
  localparam logic [6:0] ChDigit9 = 7'h39;
  localparam logic [6:0] ChQuest  = 7'h3F;
  localparam logic [6:0] ChBang   = 7'h21;
  localparam logic [6:0] ChPeriod = 7'h2E;
  localparam logic [6:0] ChComma  = 7'h2C;
  localparam logic [6:0] ChSemi   = 7'h3B;
  localparam logic [6:0] ChColon  = 7'h3A;
  localparam logic [6:0] ChUnder  = 7'h5F;
  localparam logic [6:0] ChDash   = 7'h2D;
  localparam logic [6:0] ChLParen = 7'h28;
  localparam logic [6:0] ChRParen = 7'h29;
  localparam logic [6:0] ChAt     = 7'h40;
  localparam logic [6:0] ChPct    = 7'h25;
  localparam logic [6:0] ChAmp    = 7'h26;
  localparam logic [6:0] ChDollar = 7'h24;
  localparam logic [6:0] ChHash   = 7'h23;

  // Input transaction
  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
    logic [6:0] bin_index;
  } chc_in_t;

  // Result transaction
  typedef struct packed {
    logic [6:0]  bin_code;
    logic [31:0] count;
    logic        listed;
  } chc_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic write_en;
    logic load_out;
  } chc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic out_free;
  } chc_sts_t;

  // Letters, digits and the named punctuation marks
  function automatic logic chc_is_listed(input logic [6:0] code);
    logic hit;
    hit = (code inside {[ChUpperA:ChUpperZ], [ChLowerA:ChLowerZ], [ChDigit0:ChDigit9],
                        ChQuest, ChBang, ChPeriod, ChComma, ChSemi, ChColon, ChUnder,
                        ChDash, ChLParen, ChRParen, ChAt, ChPct, ChAmp, ChDollar, ChHash});
    return hit;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/chc_ctrl.sv @@
// Controller state machine: accepts a transaction, then updates or reports.
`default_nettype none

module chc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire chc_pkg::chc_sts_t sts_i,
  output chc_pkg::chc_cmd_t      cmd_o
);
  import chc_pkg::*;

  localparam logic SIdle = 1'b0;
  localparam logic SExec = 1'b1;

  logic state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.write_en = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SExec;
        end
      end
      SExec: begin
        if (sts_i.is_read) begin
          // wait for a free output slot
          if (sts_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = SIdle;
          end
        end else begin
          cmd_o.write_en = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign in_stall_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/chc_datapath.sv @@
// Datapath: bin memory with valid bits, saturating increment, result register.
`default_nettype none

module chc_datapath #(
  parameter int NUM_BINS    = 127,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire chc_pkg::chc_in_t  in_data_i,
  input  wire chc_pkg::chc_cmd_t cmd_i,
  output chc_pkg::chc_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output chc_pkg::chc_out_t      out_data_o
);
  import chc_pkg::*;

  localparam int IdxW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // Bin storage
  logic [COUNT_WIDTH-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]    bin_vld_q;

  // Captured transaction
  logic             is_read_q;
  logic [6:0]       code_q;
  logic [IdxW-1:0]  addr_q;
  logic             in_range_q;
  logic             inc_ok_q;

  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   rd_vld_q;

  logic                   out_valid_q;
  chc_out_t               out_q;

  // Address decode of the incoming transaction
  logic [8:0]      code9;
  logic            in_range;
  logic [IdxW-1:0] addr;

  always_comb begin
    if (in_data_i.command == CmdRead) begin
      code9 = {2'b00, in_data_i.bin_index};
    end else begin
      code9 = {1'b0, in_data_i.byte_value};
    end
    in_range = (code9 < 9'(NUM_BINS));
    addr     = code9[IdxW-1:0];
  end

  // Capture transaction and read the bin
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_read_q  <= (in_data_i.command == CmdRead);
      code_q     <= in_data_i.bin_index;
      addr_q     <= addr;
      in_range_q <= in_range;
      inc_ok_q   <= in_range && (code9 != 9'd0);
      rd_data_q  <= mem_q[addr];
      rd_vld_q   <= bin_vld_q[addr];
    end
  end

  // Current count: unwritten bins and out-of-range codes read as zero
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic [63:0]            cnt_wide;

  assign cur_cnt  = (rd_vld_q && in_range_q) ? rd_data_q : '0;
  assign inc_cnt  = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
  assign cnt_wide = 64'(cur_cnt);

  // Write-back of the incremented bin
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en && inc_ok_q) begin
      mem_q[addr_q] <= inc_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
    end else if (cmd_i.write_en && inc_ok_q) begin
      bin_vld_q[addr_q] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.bin_code <= code_q;
      out_q.count    <= cnt_wide[31:0];
      out_q.listed   <= (cur_cnt != '0) && chc_is_listed(code_q);
    end
  end

  assign sts_o.is_read  = is_read_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

@@ rtl/core/char_histogram_counter.sv @@
// Character histogram counter with saturating bins: top level.
//
// Each input transaction either counts one byte (command 0) or reads one
// bin (command 1). Bytes 1 to NUM_BINS-1 add one to their bin, which
// saturates at the largest COUNT_WIDTH-bit value; byte 0 and bytes beyond
// the bins are ignored. A read returns one result transaction holding the
// bin code, its count (low 32 bits) and a listed flag, set when the count
// is nonzero and the code is a letter, a digit or one of ? ! . , ; : _ - ( )
// @ % & $ #. The bin memory is read with a registered read in the accept
// cycle and written back or reported in the execute state that follows;
// no new input is taken until that state is done. A read waits in the
// execute state only while the result register is still held by out_stall_i.
// Bins are cleared at reset by one valid bit per bin; there is no clearing
// pass and the block accepts input right after reset.
`default_nettype none

module char_histogram_counter #(
  parameter int NUM_BINS    = 127,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire chc_pkg::chc_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output chc_pkg::chc_out_t      out_data_o
);
  import chc_pkg::*;

  chc_cmd_t cmd;
  chc_sts_t sts;

  chc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chc_datapath #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
